// ===== hdl/sobel_edge_magnitude_top_macros.svh =====
// assertion macros for the sobel edge magnitude block
`ifndef SOBEL_EDGE_MAGNITUDE_TOP_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define SEM_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("sobel edge magnitude: assertion failed");
// next-cycle implication, checked out of reset
`define SEM_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("sobel edge magnitude: assertion failed");
`else
`define SEM_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define SEM_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

// ===== hdl/sem_pkg.sv =====
// shared constants, types and helpers of the sobel edge magnitude block
`default_nettype none

package sem_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int PIX_W  = 8;          // grayscale pixel
    localparam int POS_W  = 11;         // row and column positions
    localparam int SIZE_W = 12;         // size registers
    localparam int LINE_W = 2 * PIX_W;  // upper and middle line entry
    localparam int GRAD_W = 11;         // signed kernel sum, |sum| <= 1020
    localparam int ROOT_W = 8;          // magnitude
    localparam int SQ_W   = 20;         // one squared kernel sum
    localparam int SUM_W  = SQ_W + 1;   // sum of both squares

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(3);
    localparam logic [SIZE_W-1:0] WIDTH_MAX  = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_MAX = SIZE_W'(MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(512);

    // register index as decoded from the word address
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
    } t_size;

    typedef struct packed {
        logic                     hit;
        logic [POS_W-1:0]         row;
        logic [POS_W-1:0]         col;
        logic                     last;
        logic signed [GRAD_W-1:0] sx;
        logic signed [GRAD_W-1:0] sy;
    } t_win_result;

    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [SIZE_W-1:0] v,
        input logic [SIZE_W-1:0] hi
    );
        logic [SIZE_W-1:0] res;
        if (v < SIZE_MIN) begin
            res = SIZE_MIN;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sem_line_ram.sv =====
// dual line store ram, one write and one registered read port
`default_nettype none

module sem_line_ram import sem_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [POS_W-1:0]  i_waddr,
    input  logic [LINE_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [POS_W-1:0]  i_raddr,
    output logic [LINE_W-1:0] o_rdata
);

    logic [LINE_W-1:0] r_mem [0:MAX_WIDTH-1];
    logic [LINE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/sem_window.sv =====
// position tracking, line store access, 3x3 window and kernel sums
`default_nettype none

module sem_window import sem_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic             i_frame_start,
    input  logic             i_calc,
    input  t_size            i_size,
    output t_win_result      o_result
);

    logic [POS_W-1:0]  r_row;
    logic [POS_W-1:0]  r_col;
    logic [PIX_W-1:0]  r_px;
    logic [PIX_W-1:0]  r_win [0:5];
    t_win_result       r_result;

    logic [POS_W-1:0]  w_raddr;
    logic [LINE_W-1:0] w_rdata;
    logic [PIX_W-1:0]  w_top;
    logic [PIX_W-1:0]  w_mid;
    logic [SIZE_W-1:0] w_r12;
    logic [SIZE_W-1:0] w_c12;
    logic [SIZE_W-1:0] w_r_inc;
    logic [SIZE_W-1:0] w_c_inc;
    logic              w_hit;
    logic              w_last;
    logic [GRAD_W-1:0] w_left;
    logic [GRAD_W-1:0] w_right;
    logic [GRAD_W-1:0] w_upper;
    logic [GRAD_W-1:0] w_lower;

    // read is issued with the request, data is back in the calc cycle
    assign w_raddr = i_frame_start ? '0 : r_col;

    sem_line_ram u_line_ram (
        .i_clk   (i_clk),
        .i_we    (i_calc),
        .i_waddr (r_col),
        .i_wdata ({w_mid, r_px}),
        .i_re    (i_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_top = w_rdata[LINE_W-1:PIX_W];
    assign w_mid = w_rdata[PIX_W-1:0];

    assign w_r12   = SIZE_W'(r_row);
    assign w_c12   = SIZE_W'(r_col);
    assign w_r_inc = w_r12 + SIZE_W'(1);
    assign w_c_inc = w_c12 + SIZE_W'(1);

    assign w_hit  = (r_row >= POS_W'(2)) && (w_r12 < i_size.h)
                 && (r_col >= POS_W'(2)) && (w_c12 < i_size.w);
    assign w_last = (w_r_inc == i_size.h) && (w_c_inc == i_size.w);

    // column sums for sx, row sums for sy
    assign w_left  = GRAD_W'(r_win[0]) + (GRAD_W'(r_win[2]) << 1) + GRAD_W'(r_win[4]);
    assign w_right = GRAD_W'(w_top) + (GRAD_W'(w_mid) << 1) + GRAD_W'(r_px);
    assign w_upper = GRAD_W'(r_win[0]) + (GRAD_W'(r_win[1]) << 1) + GRAD_W'(w_top);
    assign w_lower = GRAD_W'(r_win[4]) + (GRAD_W'(r_win[5]) << 1) + GRAD_W'(r_px);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_accept) begin
            if (i_frame_start) begin
                r_row <= '0;
                r_col <= '0;
            end
        end else if (i_calc) begin
            r_win[0] <= r_win[1];
            r_win[1] <= w_top;
            r_win[2] <= r_win[3];
            r_win[3] <= w_mid;
            r_win[4] <= r_win[5];
            r_win[5] <= r_px;
            if (w_c_inc >= i_size.w) begin
                r_col <= '0;
                r_row <= (w_r_inc >= i_size.h) ? '0 : w_r_inc[POS_W-1:0];
            end else begin
                r_col <= w_c_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_px <= i_pixel;
        end
        if (i_calc) begin
            r_result.hit  <= w_hit;
            r_result.row  <= r_row - POS_W'(1);
            r_result.col  <= r_col - POS_W'(1);
            r_result.last <= w_last;
            r_result.sx   <= signed'(w_left - w_right);
            r_result.sy   <= signed'(w_upper - w_lower);
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== hdl/sem_isqrt.sv =====
// squares the kernel sums and takes the clamped floor square root, one bit a cycle
`default_nettype none

module sem_isqrt import sem_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_ack,
    input  logic signed [GRAD_W-1:0] i_sx,
    input  logic signed [GRAD_W-1:0] i_sy,
    output logic                     o_done,
    output logic [ROOT_W-1:0]        o_root
);

    typedef enum logic [3:0] {
        IS_IDLE = 4'b0001,
        IS_SUM  = 4'b0010,
        IS_ITER = 4'b0100,
        IS_DONE = 4'b1000
    } t_is_state;

    t_is_state r_state;
    t_is_state n_state;

    logic [SQ_W-1:0]   r_sqx;
    logic [SQ_W-1:0]   r_sqy;
    logic [SUM_W-1:0]  r_sum;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W-1:0] r_bit;

    logic signed [2*GRAD_W-1:0] w_sqx;
    logic signed [2*GRAD_W-1:0] w_sqy;
    logic [ROOT_W-1:0]          w_trial;
    logic [2*ROOT_W-1:0]        w_trial_sq;
    logic                       w_sat;

    assign w_sqx      = i_sx * i_sx;
    assign w_sqy      = i_sy * i_sy;
    assign w_trial    = r_root | r_bit;
    assign w_trial_sq = w_trial * w_trial;
    assign w_sat      = r_sum[SUM_W-1:2*ROOT_W] != '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            IS_IDLE: begin
                if (i_start) begin
                    n_state = IS_SUM;
                end
            end
            IS_SUM: begin
                n_state = IS_ITER;
            end
            IS_ITER: begin
                if (w_sat || r_bit[0]) begin
                    n_state = IS_DONE;
                end
            end
            IS_DONE: begin
                if (i_ack) begin
                    n_state = IS_IDLE;
                end
            end
            default: begin
                n_state = IS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            IS_IDLE: begin
                r_sqx <= unsigned'(w_sqx[SQ_W-1:0]);
                r_sqy <= unsigned'(w_sqy[SQ_W-1:0]);
            end
            IS_SUM: begin
                r_sum  <= SUM_W'(r_sqx) + SUM_W'(r_sqy);
                r_root <= '0;
                r_bit  <= {1'b1, {(ROOT_W-1){1'b0}}};
            end
            IS_ITER: begin
                if (w_sat) begin
                    r_root <= '1;
                end else if (w_trial_sq <= r_sum[2*ROOT_W-1:0]) begin
                    r_root <= w_trial;
                end
                r_bit <= r_bit >> 1;
            end
            default: begin
            end
        endcase
    end

    assign o_done = r_state == IS_DONE;
    assign o_root = r_root;

endmodule

`default_nettype wire

// ===== hdl/sobel_edge_magnitude_top.sv =====
// top level of the sobel 3x3 edge magnitude block
// path: line ram read, window update, squares, sum, bit-serial root and output register;
//   a sum that clamps to 255 ends the root at its first iteration; one request at a time:
//   a border pixel leaves after the check state, an interior one once its root is loaded
// reset: synchronous active low; clears positions, window, handshakes and size registers
//   (512 x 512); the line ram has no reset and is valid once two rows have passed
`default_nettype none
`include "sobel_edge_magnitude_top_macros.svh"

module sobel_edge_magnitude_top import sem_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // pixel stream in
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] pixel
    input  logic              s_axis_tuser,   // [0] frame_start
    // magnitude stream out
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // [7:0] magnitude, [18:8] out_row, [29:19] out_col
    output logic              m_axis_tlast,   // frame_done
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CALC  = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_ROOT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // size registers, taken through the clamp before use
    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;
    t_size             w_size;

    // output register, parts the pipeline from the downstream side
    logic              r_out_valid;
    logic [ROOT_W-1:0] r_mag;
    logic [POS_W-1:0]  r_out_row;
    logic [POS_W-1:0]  r_out_col;
    logic              r_out_last;

    logic              w_accept;
    logic              w_cfg_write;
    logic              w_start;
    logic              w_load;
    logic              w_root_done;
    logic [ROOT_W-1:0] w_root;
    t_win_result       w_win;
    logic [POS_W-1:0]  w_last_col;

    // ---------------- configuration port ----------------
    // low address bits are ignored, the word address picks the register
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_RESET;
            r_height <= SIZE_RESET;
        end else if (w_cfg_write) begin
            case (paddr[2])
                REG_WIDTH:  r_width  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: r_height <= pwdata[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WIDTH:  prdata = APB_DW'(r_width);
            REG_HEIGHT: prdata = APB_DW'(r_height);
            default:    prdata = '0;
        endcase
    end

    assign w_size.w = clamp_size(r_width, WIDTH_MAX);
    assign w_size.h = clamp_size(r_height, HEIGHT_MAX);

    // ---------------- sequencer ----------------
    // one request at a time: the line ram is read with the request and
    // written back in the calc cycle, so a read never meets a pending write
    // no request is taken while in reset
    assign s_axis_tready = i_rst_n && (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_start       = (r_state == ST_CHECK) && w_win.hit;
    // a finished root waits here until the output register is free
    assign w_load        = (r_state == ST_ROOT) && w_root_done
                        && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = w_win.hit ? ST_ROOT : ST_IDLE;
            end
            ST_ROOT: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- datapath ----------------
    sem_window u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_pixel       (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .i_calc        (r_state == ST_CALC),
        .i_size        (w_size),
        .o_result      (w_win)
    );

    sem_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_ack   (w_load),
        .i_sx    (w_win.sx),
        .i_sy    (w_win.sy),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // window result stays put until the next calc cycle, past the load
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mag      <= w_root;
            r_out_row  <= w_win.row;
            r_out_col  <= w_win.col;
            r_out_last <= w_win.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_col, r_out_row, r_mag};
    assign m_axis_tlast  = r_out_last;

    // ---------------- assertions ----------------
    // column of the last interior pixel is two short of the width
    assign w_last_col = POS_W'(w_size.w - SIZE_W'(2));

    `SEM_ASSERT_NEXT(a_request_to_calc, i_clk, i_rst_n, w_accept, r_state == ST_CALC)
    `SEM_ASSERT_IMPLY(a_out_interior, i_clk, i_rst_n, m_axis_tvalid, (r_out_row != '0) && (r_out_col != '0))
    `SEM_ASSERT_IMPLY(a_last_col, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, r_out_col == w_last_col)

endmodule

`default_nettype wire
